// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define KMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define KMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/kmp_pkg.sv =====
// Package: constants, controller states and command/status structs for the matcher.
`timescale 1ns / 1ps

package kmp_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int COUNT_BITS  = 16;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int BYTE_W      = 8;
  localparam int PAT_W       = 128;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_CNT_W   = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LEN  = 2'd0,
    REG_PAT_LO   = 2'd1,
    REG_PAT_HI   = 2'd2,
    REG_CNT_MODE = 2'd3
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_BUILD,
    ST_ACCEPT,
    ST_SEARCH,
    ST_BORDER
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic init;    // clear first table entry, start table build
    logic build;   // one table build step
    logic load;    // latch input word
    logic fall;    // one fallback step on the text
    logic finish;  // final compare, load result register
    logic border;  // fall back to border of the full pattern
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic build_done;
    logic srch_fall;
    logic need_border;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/kmp_ctrl.sv =====
// Controller state machine for the matcher: table build, accept, search, border.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kmp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              in_valid,
  output logic              in_stall,
  input  kmp_pkg::dp_stat_t stat,
  output kmp_pkg::ctl_cmd_t cmd
);

  kmp_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kmp_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = kmp_pkg::ST_INIT;
    end else begin
      case (state_r)
        kmp_pkg::ST_INIT:   state_nxt = kmp_pkg::ST_BUILD;
        kmp_pkg::ST_BUILD: begin
          if (stat.build_done) state_nxt = kmp_pkg::ST_ACCEPT;
        end
        kmp_pkg::ST_ACCEPT: begin
          if (in_valid) state_nxt = kmp_pkg::ST_SEARCH;
        end
        kmp_pkg::ST_SEARCH: begin
          if (!stat.srch_fall && stat.out_free) begin
            state_nxt = stat.need_border ? kmp_pkg::ST_BORDER : kmp_pkg::ST_ACCEPT;
          end
        end
        kmp_pkg::ST_BORDER: state_nxt = kmp_pkg::ST_ACCEPT;
        default:            state_nxt = kmp_pkg::ST_INIT;
      endcase
    end
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    if (!cfg_we) begin
      case (state_r)
        kmp_pkg::ST_INIT:   cmd.init = 1'b1;
        kmp_pkg::ST_BUILD:  cmd.build = !stat.build_done;
        kmp_pkg::ST_ACCEPT: begin
          in_stall = 1'b0;
          cmd.load = in_valid;
        end
        kmp_pkg::ST_SEARCH: begin
          cmd.fall   = stat.srch_fall;
          cmd.finish = !stat.srch_fall && stat.out_free;
        end
        kmp_pkg::ST_BORDER: cmd.border = 1'b1;
        default:            cmd = '0;
      endcase
    end
  end

  `KMP_ASSERT_NEXT(a_load_to_search, cmd.load, state_r == kmp_pkg::ST_SEARCH, "no search after load")
  `KMP_ASSERT(a_one_cmd, $onehot0(cmd), "more than one datapath command at once")
  `KMP_ASSERT(a_stall_in_search, state_r == kmp_pkg::ST_SEARCH |-> in_stall, "input taken during search")

endmodule

// ===== rtl/core/kmp_dpath.sv =====
// Datapath for the matcher: config registers, failure table, match state, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kmp_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [kmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kmp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [kmp_pkg::BYTE_W-1:0]         in_text_byte,
  input  logic                               in_text_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_match_end,
  output logic [kmp_pkg::OUT_CNT_W-1:0]      out_match_count,
  output logic                               out_found,
  output logic                               out_end_of_text,
  input  kmp_pkg::ctl_cmd_t                  cmd,
  output kmp_pkg::dp_stat_t                  stat
);

  localparam logic [kmp_pkg::LEN_W-1:0] PMAX = kmp_pkg::LEN_W'(kmp_pkg::PATTERN_MAX);
  localparam logic [kmp_pkg::COUNT_BITS-1:0] CNT_MAX = {kmp_pkg::COUNT_BITS{1'b1}};

  // Configuration registers
  logic [kmp_pkg::LEN_W-1:0]  len_r;
  logic [kmp_pkg::PAT_W-1:0]  pat_r;
  logic                       mode_r;

  // Failure table and build pointers
  logic [kmp_pkg::LEN_W-1:0]  ft_r [kmp_pkg::PATTERN_MAX];
  logic [kmp_pkg::LEN_W-1:0]  i_r, k_r;

  // Text state
  logic [kmp_pkg::LEN_W-1:0]      ml_r, j_r;
  logic [kmp_pkg::COUNT_BITS-1:0] count_r;
  logic                           found_r, stop_r;
  logic [kmp_pkg::BYTE_W-1:0]     c_r;
  logic                           last_r;

  // Result register
  logic                           out_valid_r;
  logic                           om_end_r, of_r, oeot_r;
  logic [kmp_pkg::OUT_CNT_W-1:0]  ocnt_r;

  logic [kmp_pkg::LEN_W-1:0]      m_eff;
  logic [kmp_pkg::IDX_W-1:0]      rd_addr;
  logic [kmp_pkg::LEN_W-1:0]      ft_rd;
  logic [kmp_pkg::BYTE_W-1:0]     pi, pk, pj;
  logic                           b_fall, c_eq, hit;
  logic [kmp_pkg::LEN_W-1:0]      kn, jn;
  logic [kmp_pkg::COUNT_BITS-1:0] cnt_new;

  function automatic logic [kmp_pkg::BYTE_W-1:0] pat_byte(
    input logic [kmp_pkg::PAT_W-1:0] pat,
    input logic [kmp_pkg::IDX_W-1:0] idx
  );
    pat_byte = pat[idx*kmp_pkg::BYTE_W +: kmp_pkg::BYTE_W];
  endfunction

  // Effective pattern length, clamped to 1..PATTERN_MAX
  always_comb begin
    if (len_r == '0)       m_eff = kmp_pkg::LEN_W'(1);
    else if (len_r > PMAX) m_eff = PMAX;
    else                   m_eff = len_r;
  end

  // Single table read port
  always_comb begin
    if (cmd.border)    rd_addr = kmp_pkg::IDX_W'(m_eff - kmp_pkg::LEN_W'(1));
    else if (cmd.fall) rd_addr = kmp_pkg::IDX_W'(j_r - kmp_pkg::LEN_W'(1));
    else               rd_addr = kmp_pkg::IDX_W'(k_r - kmp_pkg::LEN_W'(1));
  end
  assign ft_rd = ft_r[rd_addr];

  // Build compare
  assign pi     = pat_byte(pat_r, i_r[kmp_pkg::IDX_W-1:0]);
  assign pk     = pat_byte(pat_r, k_r[kmp_pkg::IDX_W-1:0]);
  assign b_fall = (k_r != '0) && (pi != pk);
  assign kn     = k_r + kmp_pkg::LEN_W'(pi == pk);

  // Search compare
  assign pj      = pat_byte(pat_r, j_r[kmp_pkg::IDX_W-1:0]);
  assign c_eq    = (c_r == pj);
  assign jn      = j_r + kmp_pkg::LEN_W'(c_eq);
  assign hit     = !stop_r && (jn == m_eff);
  assign cnt_new = count_r + kmp_pkg::COUNT_BITS'(hit && (count_r != CNT_MAX));

  // Status to controller
  always_comb begin
    stat.build_done  = (i_r >= m_eff);
    stat.srch_fall   = !stop_r && (j_r != '0) && !c_eq;
    stat.need_border = hit && mode_r && !last_r;
    stat.out_free    = !out_valid_r || !out_stall;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= kmp_pkg::LEN_W'(1);
      pat_r  <= '0;
      mode_r <= 1'b1;
    end else if (cfg_we) begin
      case (kmp_pkg::cfg_reg_t'(cfg_index))
        kmp_pkg::REG_PAT_LEN:  len_r <= cfg_wdata[kmp_pkg::LEN_W-1:0];
        kmp_pkg::REG_PAT_LO:   pat_r[kmp_pkg::CFG_DATA_W-1:0] <= cfg_wdata;
        kmp_pkg::REG_PAT_HI:   pat_r[kmp_pkg::PAT_W-1:kmp_pkg::CFG_DATA_W] <= cfg_wdata;
        kmp_pkg::REG_CNT_MODE: mode_r <= cfg_wdata[0];
        default:               mode_r <= mode_r;
      endcase
    end
  end

  // Failure table build
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= kmp_pkg::LEN_W'(1);
      k_r <= '0;
    end else if (cmd.init) begin
      i_r <= kmp_pkg::LEN_W'(1);
      k_r <= '0;
    end else if (cmd.build) begin
      if (b_fall) begin
        k_r <= ft_rd;
      end else begin
        k_r <= kn;
        i_r <= i_r + kmp_pkg::LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      ft_r[0] <= '0;
    end else if (cmd.build && !b_fall) begin
      ft_r[i_r[kmp_pkg::IDX_W-1:0]] <= kn;
    end
  end

  // Input word latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r    <= in_text_byte;
      last_r <= in_text_last;
    end
  end

  // Match state
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we || cmd.init) begin
      ml_r    <= '0;
      j_r     <= '0;
      count_r <= '0;
      found_r <= 1'b0;
      stop_r  <= 1'b0;
    end else if (cmd.load) begin
      j_r <= (ml_r >= m_eff) ? '0 : ml_r;
    end else if (cmd.fall) begin
      j_r <= ft_rd;
    end else if (cmd.finish) begin
      if (last_r) begin
        ml_r    <= '0;
        count_r <= '0;
        found_r <= 1'b0;
        stop_r  <= 1'b0;
      end else begin
        count_r <= cnt_new;
        found_r <= found_r | hit;
        if (hit) begin
          ml_r   <= '0;
          stop_r <= !mode_r;
        end else if (!stop_r) begin
          ml_r <= jn;
        end
      end
    end else if (cmd.border) begin
      ml_r <= ft_rd;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      om_end_r <= hit;
      ocnt_r   <= kmp_pkg::OUT_CNT_W'(cnt_new);
      of_r     <= found_r | hit;
      oeot_r   <= last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_end   = om_end_r;
  assign out_match_count = ocnt_r;
  assign out_found       = of_r;
  assign out_end_of_text = oeot_r;

  `KMP_ASSERT(a_ml_in_range, ml_r < m_eff, "matched length not below pattern length")
  `KMP_ASSERT(a_border_lt_i, k_r < i_r, "build border not below build index")
  `KMP_ASSERT(a_found_count, found_r == (count_r != '0), "found flag disagrees with count")
  `KMP_ASSERT_NEXT(a_finish_out, cmd.finish, out_valid_r, "finished word not presented")

endmodule

// ===== rtl/core/kmp_stream_matcher.sv =====
// Top level of the streaming KMP byte matcher: controller plus datapath.
//
// Usage: write pattern_length (0), pattern bytes 0-7 (1), bytes 8-15 (2) and
// count_mode (3) on the cfg_ port while idle. Each write restarts the text and
// rebuilds the failure table; in_stall stays high during the build. The
// effective pattern length m is 1 to 16.
// The same build runs after reset.
// Text words enter on in_valid/in_stall, one byte each, in_text_last marking
// the last byte of a text. Each byte yields exactly one result word on
// out_valid/out_stall: match end flag, saturating count, sticky found flag and
// an echo of the last marker.
// After a byte is accepted, the search state runs its table fallbacks one at
// a time and then loads the result into the output register. A new byte is
// taken only after the previous one has finished its fallbacks and result
// load, and after a match in count mode that does not end the text, also a
// border step. The single compare and table read port in the datapath sets
// this pace. A stalled result holds, and the block waits in search only when
// it must load a new result while the old one is still stalled.
// Reset is synchronous, active low; it clears the match state and the
// configuration to length 1, pattern zero, count mode on.
`timescale 1ns / 1ps

module kmp_stream_matcher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [kmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kmp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kmp_pkg::BYTE_W-1:0]     in_text_byte,
  input  logic                           in_text_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_match_end,
  output logic [kmp_pkg::OUT_CNT_W-1:0]  out_match_count,
  output logic                           out_found,
  output logic                           out_end_of_text
);

  kmp_pkg::ctl_cmd_t cmd;
  kmp_pkg::dp_stat_t stat;

  kmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  kmp_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_text_byte    (in_text_byte),
    .in_text_last    (in_text_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_end   (out_match_end),
    .out_match_count (out_match_count),
    .out_found       (out_found),
    .out_end_of_text (out_end_of_text),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

// ===== tb/tb_kmp_stream_matcher.sv =====
// Testbench for the KMP stream matcher: directed and random text checked against a KMP predictor.
`timescale 1ns / 1ps

module tb_kmp_stream_matcher;
  import kmp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 1300;

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;

  // One result word as the block reports it
  typedef struct packed {
    logic                 match_end;
    logic [OUT_CNT_W-1:0] match_count;
    logic                 found;
    logic                 end_of_text;
  } match_word_t;

  // Predicts the result word of every accepted text byte and checks the block against it
  class kmp_scoreboard;
    logic [LEN_W-1:0]      len_reg;
    logic [CFG_DATA_W-1:0] lo_reg;
    logic [CFG_DATA_W-1:0] hi_reg;
    logic                  mode_reg;
    int                    border[PATTERN_MAX];
    int                    prefix_len;
    logic [OUT_CNT_W-1:0]  hits;
    bit                    seen_match;
    bit                    halted;
    match_word_t           expected_q[$];
    int                    errors;

    function new();
      len_reg  = LEN_W'(1);
      lo_reg   = '0;
      hi_reg   = '0;
      mode_reg = 1'b1;
      errors   = 0;
      rebuild_borders();
    endfunction

    // zero means one, anything past the table size is clipped
    function int active_len();
      int m;
      m = int'(len_reg);
      if (m == 0) m = 1;
      if (m > PATTERN_MAX) m = PATTERN_MAX;
      return m;
    endfunction

    function logic [7:0] pat_at(int i);
      return (i < 8) ? lo_reg[8*i +: 8] : hi_reg[8*(i-8) +: 8];
    endfunction

    function void clear_text();
      prefix_len = 0;
      hits       = '0;
      seen_match = 1'b0;
      halted     = 1'b0;
    endfunction

    // longest proper border of every pattern prefix; any write restarts the text
    function void rebuild_borders();
      int m;
      int k;
      m = active_len();
      k = 0;
      foreach (border[i]) border[i] = 0;
      for (int i = 1; i < m; i++) begin
        while (k > 0 && pat_at(i) != pat_at(k)) k = border[k-1];
        if (pat_at(i) == pat_at(k)) k++;
        border[i] = k;
      end
      clear_text();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_PAT_LEN:  len_reg  = v[LEN_W-1:0];
        REG_PAT_LO:   lo_reg   = v;
        REG_PAT_HI:   hi_reg   = v;
        REG_CNT_MODE: mode_reg = v[0];
        default: ;
      endcase
      rebuild_borders();
    endfunction

    // advance the match state by one text byte and queue the word it gives
    function void note_byte(logic [7:0] b, logic last);
      int          m;
      int          j;
      match_word_t w;
      m = active_len();
      w.match_end = 1'b0;
      if (!halted) begin
        j = prefix_len;
        if (j >= m) j = 0;
        while (j > 0 && b != pat_at(j)) j = border[j-1];
        if (b == pat_at(j)) j++;
        if (j == m) begin
          w.match_end = 1'b1;
          seen_match  = 1'b1;
          if (hits != '1) hits++;
          if (mode_reg) begin
            j = border[m-1];
          end else begin
            halted = 1'b1;
            j = 0;
          end
        end
        prefix_len = j;
      end
      w.match_count = hits;
      w.found       = seen_match;
      w.end_of_text = last;
      expected_q.push_back(w);
      if (last) clear_text();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void check_result(match_word_t got);
      match_word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: end=%0d count=%0d found=%0d eot=%0d",
                   got.match_end, got.match_count, got.found, got.end_of_text);
        return;
      end
      want = expected_q.pop_front();
      if (got.match_end !== want.match_end || got.match_count !== want.match_count ||
          got.found !== want.found || got.end_of_text !== want.end_of_text) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected end=%0d count=%0d found=%0d eot=%0d, ",
                    "got end=%0d count=%0d found=%0d eot=%0d"},
                   want.match_end, want.match_count, want.found, want.end_of_text,
                   got.match_end, got.match_count, got.found, got.end_of_text);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_text_byte;
  logic                  in_text_last;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_match_end;
  logic [OUT_CNT_W-1:0]  out_match_count;
  logic                  out_found;
  logic                  out_end_of_text;

  kmp_scoreboard sb = new();
  int            in_gap_max  = 0;
  int            out_gap_max = 0;
  int            random_sent = 0;
  int            idle_cycles = 0;
  logic [7:0]    sym[3];
  int            n_sym = 2;

  kmp_stream_matcher u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_text_last    (in_text_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_end   (out_match_end),
    .out_match_count (out_match_count),
    .out_found       (out_found),
    .out_end_of_text (out_end_of_text)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** kmp_stream_matcher: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one text byte after a random gap; valid stays up when the gap is zero
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_text_last <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_byte(b, last);
  endtask

  // Random text byte, now and then closing the text
  task automatic emit(input logic [7:0] b);
    send_byte(b, $urandom_range(0, 11) == 0);
    random_sent++;
  endtask

  // Register write, then let the table build finish
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    int waited;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    waited = 0;
    while (in_stall !== 1'b0 && waited < 40) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Drain every pending result; a border step may still run after the last one
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pattern_word();
    logic [CFG_DATA_W-1:0] w;
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    for (int b = 0; b < 8; b++) w[8*b +: 8] = sym[$urandom_range(0, n_sym - 1)];
    return w;
  endfunction

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 18;
    endcase
  endfunction

  // Result side: random stall before each word, check on acceptance
  initial begin : result_side
    match_word_t got;
    int          gap;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got.match_end   = out_match_end;
      got.match_count = out_match_count;
      got.found       = out_found;
      got.end_of_text = out_end_of_text;
      sb.check_result(got);
    end
  end

  // Stimulus
  initial begin : stimulus
    int                    phase_start;
    int                    n_bytes;
    int                    plen;
    int                    cut;
    int                    n_writes;
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] v;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_PAT_LEN;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_text_byte <= '0;
    in_text_last <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset pattern: a single zero byte, counting
    in_gap_max  = 3;
    out_gap_max = 18;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // Length zero acts as one
    settle();
    write_reg(REG_PAT_LO, '1);
    write_reg(REG_PAT_LEN, '0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1);

    // Existence mode stops after the first "aba"
    settle();
    in_gap_max  = 18;
    out_gap_max = 3;
    write_reg(REG_PAT_LO, {48'h0, CH_A, CH_B, CH_A});
    write_reg(REG_PAT_LEN, 64'd3);
    write_reg(REG_CNT_MODE, '0);
    send_byte(CH_A, 1'b0);
    send_byte(CH_B, 1'b0);
    send_byte(CH_A, 1'b0);
    send_byte(CH_B, 1'b0);
    send_byte(CH_A, 1'b0);
    send_byte(CH_B, 1'b0);
    send_byte(CH_A, 1'b1);

    // Count mode with overlap, then a write restarts the open text
    settle();
    write_reg(REG_CNT_MODE, '1);
    send_byte(CH_A, 1'b0);
    send_byte(CH_B, 1'b0);
    send_byte(CH_A, 1'b0);
    send_byte(CH_B, 1'b0);
    send_byte(CH_A, 1'b0);
    settle();
    write_reg(REG_PAT_HI, '1);
    send_byte(CH_A, 1'b0);
    send_byte(CH_B, 1'b0);
    send_byte(CH_A, 1'b1);

    // Random phases: new settings, gaps and a stretch of text each
    while (random_sent < RANDOM_BYTES) begin
      settle();
      n_sym = $urandom_range(2, 3);
      foreach (sym[i]) sym[i] = 8'($urandom_range(0, 255));
      in_gap_max  = pick_gap_max();
      out_gap_max = pick_gap_max();
      n_writes = $urandom_range(1, 3);
      for (int w = 0; w < n_writes; w++) begin
        idx = cfg_reg_t'($urandom_range(0, 3));
        v   = {$urandom, $urandom};
        case (idx)
          REG_PAT_LEN: begin
            case ($urandom_range(0, 9))
              0: v[LEN_W-1:0] = LEN_W'(0);
              1: v[LEN_W-1:0] = LEN_W'(1);
              2: v[LEN_W-1:0] = LEN_W'(PATTERN_MAX);
              3: v[LEN_W-1:0] = LEN_W'($urandom_range(PATTERN_MAX + 1, 31));
              default: v[LEN_W-1:0] = LEN_W'($urandom_range(2, 6));
            endcase
          end
          REG_PAT_LO, REG_PAT_HI: v = pattern_word();
          default: ;
        endcase
        write_reg(idx, v);
      end

      n_bytes     = $urandom_range(20, 80);
      phase_start = random_sent;
      plen        = sb.active_len();
      while (random_sent - phase_start < n_bytes) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            cut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, plen) : plen;
            for (int k = 0; k < cut; k++) emit(sb.pat_at(k));
          end
          8: emit(8'($urandom_range(0, 255)));
          default: emit(sym[$urandom_range(0, n_sym - 1)]);
        endcase
      end
      // most phases close their text, the rest leave it for the next write
      if ($urandom_range(0, 2) != 0) begin
        send_byte(sym[0], 1'b1);
        random_sent++;
      end
    end

    // Drain and finish
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("** kmp_stream_matcher: PASSED **");
    else
      $display("** kmp_stream_matcher: FAILED **");
    $finish;
  end

endmodule

// ===== kmp_stream_matcher.f =====
+incdir+rtl/core
rtl/core/kmp_pkg.sv
rtl/core/kmp_ctrl.sv
rtl/core/kmp_dpath.sv
rtl/core/kmp_stream_matcher.sv
tb/tb_kmp_stream_matcher.sv
